// ===== rtl/jbl_pkg.sv =====
// Shared types, codes and character constants for the JSON byte lexer.
// No dependencies; every other file refers to this package by scoped names.

package jbl_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_document;
    } text_word_t;

    typedef struct packed {
        logic [3:0]         token_kind;
        logic [2:0]         error_code;
        logic [31:0]        start_position;
        logic [31:0]        end_position;
        logic signed [63:0] integer_value;
        logic               bool_value;
        logic               last_of_run;
    } token_word_t;

    typedef struct packed {
        logic slot0;
        logic slot1;
    } push_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] TOK_LBRACE  = 4'd0;
    localparam logic [3:0] TOK_RBRACE  = 4'd1;
    localparam logic [3:0] TOK_LBRACK  = 4'd2;
    localparam logic [3:0] TOK_RBRACK  = 4'd3;
    localparam logic [3:0] TOK_COLON   = 4'd4;
    localparam logic [3:0] TOK_COMMA   = 4'd5;
    localparam logic [3:0] TOK_STRING  = 4'd6;
    localparam logic [3:0] TOK_INTEGER = 4'd7;
    localparam logic [3:0] TOK_DOUBLE  = 4'd8;
    localparam logic [3:0] TOK_BOOL    = 4'd9;
    localparam logic [3:0] TOK_NULL    = 4'd10;
    localparam logic [3:0] TOK_ERROR   = 4'd11;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CHAR       = 3'd1;
    localparam logic [2:0] ERR_ESCAPE     = 3'd2;
    localparam logic [2:0] ERR_UNTERM     = 3'd3;
    localparam logic [2:0] ERR_LITERAL    = 3'd4;
    localparam logic [2:0] ERR_MINUS      = 3'd5;
    localparam logic [2:0] ERR_NO_DIGIT   = 3'd6;
    localparam logic [2:0] ERR_PERIOD     = 3'd7;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [63:0] MAG_LIMIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_LOW    = 64'h0CCC_CCCC_CCCC_CCCC;
    localparam logic [63:0] CAP_NINE   = 64'h0CCC_CCCC_CCCC_CCCB;

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            LIT_FALSE:
            begin
                unique case (idx)
                    3'd0: ch = CH_F;
                    3'd1: ch = CH_A;
                    3'd2: ch = CH_L;
                    3'd3: ch = CH_S;
                    3'd4: ch = CH_E;
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL:
            begin
                unique case (idx)
                    3'd0: ch = CH_N;
                    3'd1: ch = CH_U;
                    3'd2: ch = CH_L;
                    3'd3: ch = CH_L;
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                unique case (idx)
                    3'd0: ch = CH_T;
                    3'd1: ch = CH_R;
                    3'd2: ch = CH_U;
                    3'd3: ch = CH_E;
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

// ===== rtl/json_byte_lexer.sv =====
// Top level of the JSON byte lexer: lexer core plus result queue.
// Depends on jbl_pkg, jbl_core and jbl_queue.
//
// Usage:
//   text channel (text_valid/text_stall/text_word) carries one document byte per
//   word, with end_of_document set on the last byte of each document.
//   token channel (token_valid/token_stall/token_word) carries token words: punctuation,
//   string, integer, double, bool, null or error, with start and end byte offsets.
//   A byte yields zero, one or two token words; last_of_run marks the final one.
// Timing:
//   A byte is captured in the input register, classified from there once the queue
//   has room and written into a four-entry result queue, from which its token
//   words are offered in order.
//   A byte is taken every cycle while the queue holds two or fewer words; bytes that
//   give two words each are held back by the one-word queue read.
// Reset and stall:
//   Reset empties the input register and the queue and sets the byte offset to 0.
//   End of document also returns all lexer state and the offset to 0.
//   While token_stall is high the offered word holds; once the queue holds more than
//   two words, a byte in the input register holds and text_stall rises until room returns.

module json_byte_lexer #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  jbl_pkg::text_word_t  text_word,
    output logic                 token_valid,
    input  logic                 token_stall,
    output jbl_pkg::token_word_t token_word
);

    logic                 room;
    jbl_pkg::push_t       push;
    jbl_pkg::token_word_t res0;
    jbl_pkg::token_word_t res1;

    jbl_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_word  (text_word),
        .room       (room),
        .push       (push),
        .res0       (res0),
        .res1       (res1)
    );

    jbl_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data0       (res0),
        .data1       (res1),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule

// ===== rtl/jbl_core.sv =====
// Input register and lexer state: classifies one byte per cycle while the queue has room, into up to two tokens.
// Depends on jbl_pkg; feeds the result queue jbl_queue.

module jbl_core #(
    parameter int POSITION_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  jbl_pkg::text_word_t text_word,
    input  logic                room,
    output jbl_pkg::push_t      push,
    output jbl_pkg::token_word_t res0,
    output jbl_pkg::token_word_t res1
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_ESCAPE  = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_LITERAL = 3'd4;
    localparam logic [2:0] MODE_ERROR   = 3'd5;

    localparam int FLAG_MINUS  = 0;
    localparam int FLAG_DIGIT  = 1;
    localparam int FLAG_PERIOD = 2;

    typedef logic [POSITION_BITS-1:0] pos_t;

    logic                in_vld_reg, in_vld_next;
    jbl_pkg::text_word_t in_word_reg;

    logic [2:0]  mode_reg,  mode_next;
    logic [1:0]  kind_reg,  kind_next;
    logic [2:0]  idx_reg,   idx_next;
    logic [2:0]  flags_reg, flags_next;
    logic [63:0] acc_reg,   acc_next;
    logic [63:0] neg_reg,   neg_next;
    pos_t        start_reg, start_next;
    pos_t        pos_reg,   pos_next;

    logic        fire;
    logic        accept;
    logic [7:0]  ch;
    logic        eod;
    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] base_acc, base_neg;
    logic        over;
    logic [63:0] sum_acc, sum_neg;
    logic [2:0]  idx_inc;
    logic        a_vld, b_vld;
    jbl_pkg::token_word_t a_res, b_res;

    function automatic jbl_pkg::token_word_t make_res(
        input logic [3:0]         kind,
        input logic [2:0]         code,
        input pos_t               from_pos,
        input pos_t               to_pos,
        input logic signed [63:0] ival,
        input logic               bval
    );
        jbl_pkg::token_word_t r;
        r.token_kind     = kind;
        r.error_code     = code;
        r.start_position = 32'(from_pos);
        r.end_position   = 32'(to_pos);
        r.integer_value  = ival;
        r.bool_value     = bval;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    function automatic jbl_pkg::token_word_t num_res(
        input logic [2:0]  flags,
        input logic [63:0] acc,
        input logic [63:0] neg,
        input pos_t        from_pos,
        input pos_t        to_pos
    );
        logic [63:0] v;
        if (flags[FLAG_MINUS])
        begin
            v = neg;
        end
        else if (acc[63])
        begin
            v = jbl_pkg::SAT_MAX;
        end
        else
        begin
            v = acc;
        end
        if (flags[FLAG_PERIOD])
        begin
            return make_res(jbl_pkg::TOK_DOUBLE, jbl_pkg::ERR_NONE, from_pos, to_pos, '0, 1'b0);
        end
        return make_res(jbl_pkg::TOK_INTEGER, jbl_pkg::ERR_NONE, from_pos, to_pos,
                        $signed(v), 1'b0);
    endfunction

    function automatic jbl_pkg::token_word_t err_res(
        input logic [2:0] code,
        input pos_t       from_pos,
        input pos_t       to_pos
    );
        return make_res(jbl_pkg::TOK_ERROR, code, from_pos, to_pos, '0, 1'b0);
    endfunction

    function automatic logic escape_ok(input logic [7:0] c);
        return c == jbl_pkg::CH_QUOTE || c == jbl_pkg::CH_BSLASH || c == jbl_pkg::CH_SLASH
            || c == jbl_pkg::CH_B || c == jbl_pkg::CH_F || c == jbl_pkg::CH_N
            || c == jbl_pkg::CH_R || c == jbl_pkg::CH_T || c == jbl_pkg::CH_U;
    endfunction

    assign fire        = in_vld_reg && room;
    assign text_stall  = in_vld_reg && !room;
    assign accept      = text_valid && !text_stall;
    assign in_vld_next = accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    assign ch       = in_word_reg.text_byte;
    assign eod      = in_word_reg.end_of_document;
    assign is_digit = (ch >= jbl_pkg::CH_ZERO) && (ch <= jbl_pkg::CH_NINE);
    assign digit    = ch[3:0];
    assign idx_inc  = idx_reg + 3'd1;

    // Decimal accumulate on the magnitude and its negation side by side.
    assign base_acc = (mode_reg == MODE_NUMBER) ? acc_reg : '0;
    assign base_neg = (mode_reg == MODE_NUMBER) ? neg_reg : '0;
    assign over     = base_acc > ((digit == 4'd9) ? jbl_pkg::CAP_NINE : jbl_pkg::CAP_LOW);
    assign sum_acc  = over ? jbl_pkg::MAG_LIMIT
                           : (base_acc << 3) + (base_acc << 1) + {60'd0, digit};
    assign sum_neg  = over ? jbl_pkg::MAG_LIMIT
                           : (base_neg << 3) + (base_neg << 1) - {60'd0, digit};

    always_comb
    begin
        logic sb;
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        a_vld      = 1'b0;
        a_res      = '0;
        b_vld      = 1'b0;
        b_res      = '0;
        sb         = 1'b0;

        unique case (mode_reg)
            MODE_STRING:
            begin
                if (ch == jbl_pkg::CH_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else if (ch == jbl_pkg::CH_QUOTE)
                begin
                    b_vld     = 1'b1;
                    b_res     = make_res(jbl_pkg::TOK_STRING, jbl_pkg::ERR_NONE,
                                         start_reg, pos_reg, '0, 1'b0);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_ESCAPE:
            begin
                if (escape_ok(ch))
                begin
                    mode_next = MODE_STRING;
                end
                else
                begin
                    b_vld     = 1'b1;
                    b_res     = err_res(jbl_pkg::ERR_ESCAPE, start_reg, pos_reg);
                    mode_next = MODE_ERROR;
                end
            end
            MODE_LITERAL:
            begin
                if (idx_reg < jbl_pkg::lit_len(kind_reg)
                    && ch == jbl_pkg::lit_char(kind_reg, idx_reg))
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= jbl_pkg::lit_len(kind_reg))
                    begin
                        b_vld     = 1'b1;
                        b_res     = (kind_reg == jbl_pkg::LIT_NULL)
                            ? make_res(jbl_pkg::TOK_NULL, jbl_pkg::ERR_NONE,
                                       start_reg, pos_reg, '0, 1'b0)
                            : make_res(jbl_pkg::TOK_BOOL, jbl_pkg::ERR_NONE,
                                       start_reg, pos_reg, '0,
                                       kind_reg != jbl_pkg::LIT_FALSE);
                        mode_next = MODE_IDLE;
                    end
                end
                else
                begin
                    b_vld     = 1'b1;
                    b_res     = err_res(jbl_pkg::ERR_LITERAL, start_reg, pos_reg);
                    mode_next = MODE_ERROR;
                end
            end
            MODE_NUMBER:
            begin
                if (ch == jbl_pkg::CH_MINUS)
                begin
                    b_vld     = 1'b1;
                    b_res     = err_res(jbl_pkg::ERR_MINUS, start_reg, pos_reg);
                    mode_next = MODE_ERROR;
                end
                else if (ch == jbl_pkg::CH_PERIOD)
                begin
                    if (!flags_reg[FLAG_DIGIT])
                    begin
                        b_vld     = 1'b1;
                        b_res     = err_res(jbl_pkg::ERR_NO_DIGIT, start_reg, pos_reg);
                        mode_next = MODE_ERROR;
                    end
                    else if (flags_reg[FLAG_PERIOD])
                    begin
                        b_vld     = 1'b1;
                        b_res     = err_res(jbl_pkg::ERR_PERIOD, start_reg, pos_reg);
                        mode_next = MODE_ERROR;
                    end
                    else
                    begin
                        flags_next[FLAG_PERIOD] = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    flags_next[FLAG_DIGIT] = 1'b1;
                    if (!flags_reg[FLAG_PERIOD])
                    begin
                        acc_next = sum_acc;
                        neg_next = sum_neg;
                    end
                end
                else
                begin
                    a_vld     = 1'b1;
                    a_res     = num_res(flags_reg, acc_reg, neg_reg, start_reg,
                                        pos_reg - pos_t'(1));
                    mode_next = MODE_IDLE;
                    sb        = 1'b1;
                end
            end
            MODE_ERROR:
            begin
            end
            default:
            begin
                mode_next = MODE_IDLE;
                sb        = 1'b1;
            end
        endcase

        if (sb)
        begin
            start_next = pos_reg;
            unique case (ch)
                jbl_pkg::CH_LBRACE, jbl_pkg::CH_RBRACE, jbl_pkg::CH_LBRACK,
                jbl_pkg::CH_RBRACK, jbl_pkg::CH_COLON, jbl_pkg::CH_COMMA:
                begin
                    b_vld = 1'b1;
                    b_res = make_res(
                        (ch == jbl_pkg::CH_LBRACE) ? jbl_pkg::TOK_LBRACE :
                        (ch == jbl_pkg::CH_RBRACE) ? jbl_pkg::TOK_RBRACE :
                        (ch == jbl_pkg::CH_LBRACK) ? jbl_pkg::TOK_LBRACK :
                        (ch == jbl_pkg::CH_RBRACK) ? jbl_pkg::TOK_RBRACK :
                        (ch == jbl_pkg::CH_COLON)  ? jbl_pkg::TOK_COLON  : jbl_pkg::TOK_COMMA,
                        jbl_pkg::ERR_NONE, pos_reg, pos_reg, '0, 1'b0);
                end
                jbl_pkg::CH_QUOTE:
                begin
                    mode_next = MODE_STRING;
                end
                jbl_pkg::CH_SPACE, jbl_pkg::CH_TAB, jbl_pkg::CH_CR, jbl_pkg::CH_LF:
                begin
                end
                jbl_pkg::CH_T, jbl_pkg::CH_F, jbl_pkg::CH_N:
                begin
                    kind_next = (ch == jbl_pkg::CH_T) ? jbl_pkg::LIT_TRUE :
                                (ch == jbl_pkg::CH_F) ? jbl_pkg::LIT_FALSE : jbl_pkg::LIT_NULL;
                    idx_next  = 3'd1;
                    mode_next = MODE_LITERAL;
                end
                jbl_pkg::CH_MINUS:
                begin
                    flags_next = 3'b001;
                    acc_next   = '0;
                    neg_next   = '0;
                    mode_next  = MODE_NUMBER;
                end
                jbl_pkg::CH_PERIOD:
                begin
                    b_vld     = 1'b1;
                    b_res     = err_res(jbl_pkg::ERR_NO_DIGIT, pos_reg, pos_reg);
                    mode_next = MODE_ERROR;
                end
                default:
                begin
                    if (is_digit)
                    begin
                        flags_next = 3'b010;
                        acc_next   = sum_acc;
                        neg_next   = sum_neg;
                        mode_next  = MODE_NUMBER;
                    end
                    else
                    begin
                        b_vld     = 1'b1;
                        b_res     = err_res(jbl_pkg::ERR_CHAR, pos_reg, pos_reg);
                        mode_next = MODE_ERROR;
                    end
                end
            endcase
        end

        if (eod)
        begin
            if (mode_next == MODE_STRING || mode_next == MODE_ESCAPE)
            begin
                b_vld = 1'b1;
                b_res = err_res(jbl_pkg::ERR_UNTERM, start_next, pos_reg);
            end
            else if (mode_next == MODE_LITERAL)
            begin
                b_vld = 1'b1;
                b_res = err_res(jbl_pkg::ERR_LITERAL, start_next, pos_reg);
            end
            else if (mode_next == MODE_NUMBER)
            begin
                b_vld = 1'b1;
                b_res = num_res(flags_next, acc_next, neg_next, start_next, pos_reg);
            end
            mode_next  = MODE_IDLE;
            kind_next  = '0;
            idx_next   = '0;
            flags_next = '0;
            acc_next   = '0;
            neg_next   = '0;
            start_next = '0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + pos_t'(1);
        end
    end

    always_comb
    begin
        push.slot0       = fire && (a_vld || b_vld);
        push.slot1       = fire && a_vld && b_vld;
        res0             = a_vld ? a_res : b_res;
        res0.last_of_run = !(a_vld && b_vld);
        res1             = b_res;
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= text_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            kind_reg   <= '0;
            idx_reg    <= '0;
            flags_reg  <= '0;
            acc_reg    <= '0;
            neg_reg    <= '0;
            start_reg  <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                kind_reg  <= kind_next;
                idx_reg   <= idx_next;
                flags_reg <= flags_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

// ===== rtl/jbl_queue.sv =====
// Result queue: takes up to two token words per cycle, hands out one per cycle while token_stall is low.
// Depends on jbl_pkg; fed by jbl_core.

module jbl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jbl_pkg::push_t       push,
    input  jbl_pkg::token_word_t data0,
    input  jbl_pkg::token_word_t data1,
    output logic                 room,
    output logic                 token_valid,
    input  logic                 token_stall,
    output jbl_pkg::token_word_t token_word
);

    localparam int DEPTH    = jbl_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam logic [PTR_BITS:0] ROOM_LIMIT = (PTR_BITS + 1)'(DEPTH - 2);

    jbl_pkg::token_word_t mem_reg [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg,  count_next;
    logic [PTR_BITS-1:0] wr_ptr_inc;
    logic [PTR_BITS:0]   push_cnt;
    logic                pop;

    assign token_valid = count_reg != '0;
    assign token_word  = mem_reg[rd_ptr_reg];
    assign room        = count_reg <= ROOM_LIMIT;
    assign pop         = token_valid && !token_stall;
    assign wr_ptr_inc  = wr_ptr_reg + PTR_BITS'(1);
    assign push_cnt    = (PTR_BITS + 1)'(push.slot0) + (PTR_BITS + 1)'(push.slot1);
    assign wr_ptr_next = wr_ptr_reg + push_cnt[PTR_BITS-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + push_cnt - (PTR_BITS + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.slot0)
        begin
            mem_reg[wr_ptr_reg] <= data0;
        end
        if (push.slot1)
        begin
            mem_reg[wr_ptr_inc] <= data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/jbl_checker.sv =====
// Port-level checks for the JSON byte lexer, bound to the top level.
// Depends on jbl_pkg and json_byte_lexer.

module jbl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 text_valid,
    input logic                 text_stall,
    input jbl_pkg::text_word_t  text_word,
    input logic                 token_valid,
    input logic                 token_stall,
    input jbl_pkg::token_word_t token_word
);

    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_stall |=> text_valid && $stable(text_word))
        else $error("text word changed while stalled");

    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_word))
        else $error("token word changed while stalled");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> ((token_word.token_kind == jbl_pkg::TOK_ERROR)
                         == (token_word.error_code != jbl_pkg::ERR_NONE)))
        else $error("error code does not match token kind");

    a_int_value: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_word.token_kind != jbl_pkg::TOK_INTEGER
            |-> token_word.integer_value == '0)
        else $error("integer value on a non-integer token");

    a_bool_value: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_word.bool_value |-> token_word.token_kind == jbl_pkg::TOK_BOOL)
        else $error("bool value on a non-bool token");

endmodule

bind json_byte_lexer jbl_checker u_jbl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_word   (text_word),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word)
);
